[design/dhb_pkg.sv]
// Shared types and codes for the dual H-bridge PWM speed ramp block.
`default_nettype none
package dhb_pkg;

  // Command kinds carried by an input item
  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_RAMP  = 2'd1;
  localparam logic [1:0] KIND_BRAKE = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  // Accepted speed range in percent
  localparam logic signed [7:0] SPEED_MAX = 8'sd100;
  localparam logic signed [7:0] SPEED_MIN = -8'sd100;

  // Status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK,
    ST_DIV,
    ST_POST,
    ST_OUT
  } state_t;

  // What the running division computes
  typedef enum logic [1:0] {
    OP_INTV,   // ramp interval count
    OP_DUE,    // elapsed time at which the next step is due
    OP_RVAL,   // interpolated ramp speed
    OP_DUTY    // pin duty of a speed
  } op_t;

endpackage
`default_nettype wire

[design/dual_hbridge_pwm_speed_ramp_top.sv]
// Dual H-bridge PWM driver with timed speed ramps, one shared multiply-divide unit.
//
// Input channel (in_valid / in_stall): one item is a command for a channel
// (set speed, ramp to speed, brake) or a one millisecond tick that advances
// both channels' ramps. Each item produces exactly one result item on the
// output channel (out_valid / out_stall) carrying all four pin duties, the
// status of the command, both ramping flags and both applied speeds.
// Every duty magnitude (the full brake duty apart), interval, due time and
// interpolation value goes through one multiplier whose product is registered
// into a restoring divider that retires one quotient bit per cycle. The
// product is PW bits wide (34 with default parameters). Brake and
// out-of-range commands use no division, set speed 1 division, ramp start
// 3 divisions and a tick 0 to 6 divisions, depending on which channels
// are ramping and which of them take a ramp step.
// One item is worked on at a time: in_stall is high from acceptance until
// the result item has been taken. While the receiver holds out_stall the
// result holds steady and no new item enters.
// After reset all pins coast (duty zero), speeds are zero and no ramp runs.
`default_nettype none
module dual_hbridge_pwm_speed_ramp_top
  import dhb_pkg::*;
#(
  parameter int DUTY_BITS    = 10,
  parameter int STEP_MS      = 10,
  parameter int RAMP_MS_BITS = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // input items
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire [1:0]                  in_kind,
  input  wire                        in_channel,
  input  wire signed [7:0]           in_speed_pct,
  input  wire [15:0]                 in_ramp_ms,
  // result items
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [DUTY_BITS-1:0]       out_duty_a_fwd,
  output logic [DUTY_BITS-1:0]       out_duty_a_rev,
  output logic [DUTY_BITS-1:0]       out_duty_b_fwd,
  output logic [DUTY_BITS-1:0]       out_duty_b_rev,
  output logic                       out_status,
  output logic                       out_ramping_a,
  output logic                       out_ramping_b,
  output logic signed [7:0]          out_speed_a,
  output logic signed [7:0]          out_speed_b
);

  // Operand width covers ms+STEP_MS-1, the step count and the duty maximum.
  localparam int MW = RAMP_MS_BITS;
  localparam int NW = RAMP_MS_BITS + 1;
  localparam int OW = ((RAMP_MS_BITS > 16) ? RAMP_MS_BITS : 16) + 1;
  localparam int PW = 2 * OW;
  localparam int CW = $clog2(PW + 1);

  localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

  // Sequencer
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  // Latched item
  logic [1:0]        kind_r, kind_nxt;
  logic              ch_r, ch_nxt;
  logic signed [7:0] spd_r, spd_nxt;
  logic [MW-1:0]     ms_r, ms_nxt;
  logic              status_r, status_nxt;
  logic signed [7:0] val_r, val_nxt;

  // Per-channel state
  logic signed [7:0]     applied_r [2], applied_nxt [2];
  logic [DUTY_BITS-1:0]  fwd_r [2], fwd_nxt [2];
  logic [DUTY_BITS-1:0]  rev_r [2], rev_nxt [2];
  logic                  active_r [2], active_nxt [2];
  logic signed [7:0]     start_r [2], start_nxt [2];
  logic signed [8:0]     diff_r [2], diff_nxt [2];
  logic [MW-1:0]         total_r [2], total_nxt [2];
  logic [MW-1:0]         intv_r [2], intv_nxt [2];
  logic [NW-1:0]         idx_r [2], idx_nxt [2];
  logic [MW-1:0]         elapsed_r [2], elapsed_nxt [2];

  // Shared multiply-divide unit
  logic [PW-1:0] q_r, q_nxt;
  logic [OW-1:0] rem_r, rem_nxt;
  logic [OW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          div_go;
  op_t           div_op;
  logic [OW-1:0] mul_a, mul_b, div_den;
  logic [PW-1:0] prod;
  logic [OW:0]   shifted, trial;
  logic          fits;

  logic [MW+15:0]    ms_wide;
  logic [7:0]        spd_abs;
  logic [7:0]        val_abs;
  logic [7:0]        diff_abs;
  logic signed [9:0] rval_sum;
  logic [9:0]        q_lo;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  assign out_duty_a_fwd = fwd_r[0];
  assign out_duty_a_rev = rev_r[0];
  assign out_duty_b_fwd = fwd_r[1];
  assign out_duty_b_rev = rev_r[1];
  assign out_status     = status_r;
  assign out_ramping_a  = active_r[0];
  assign out_ramping_b  = active_r[1];
  assign out_speed_a    = applied_r[0];
  assign out_speed_b    = applied_r[1];

  // Only the low RAMP_MS_BITS bits of the duration are used.
  assign ms_wide = {{MW{1'b0}}, in_ramp_ms};

  assign prod    = mul_a * mul_b;
  assign shifted = {rem_r, q_r[PW-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = ~trial[OW];

  assign spd_abs  = spd_r[7] ? 8'(-spd_r) : 8'(spd_r);
  assign val_abs  = val_r[7] ? 8'(-val_r) : 8'(val_r);
  assign diff_abs = diff_r[ch_r][8] ? 8'(-diff_r[ch_r]) : diff_r[ch_r][7:0];
  assign q_lo     = {2'b00, q_r[7:0]};
  assign rval_sum = 10'(start_r[ch_r])
                  + (diff_r[ch_r][8] ? 10'(-q_lo) : q_lo);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    kind_nxt    = kind_r;
    ch_nxt      = ch_r;
    spd_nxt     = spd_r;
    ms_nxt      = ms_r;
    status_nxt  = status_r;
    val_nxt     = val_r;
    applied_nxt = applied_r;
    fwd_nxt     = fwd_r;
    rev_nxt     = rev_r;
    active_nxt  = active_r;
    start_nxt   = start_r;
    diff_nxt    = diff_r;
    total_nxt   = total_r;
    intv_nxt    = intv_r;
    idx_nxt     = idx_r;
    elapsed_nxt = elapsed_r;
    q_nxt       = q_r;
    rem_nxt     = rem_r;
    den_nxt     = den_r;
    cnt_nxt     = cnt_r;
    div_go      = 1'b0;
    div_op      = OP_DUTY;
    mul_a       = '0;
    mul_b       = '0;
    div_den     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          ch_nxt    = in_channel;
          spd_nxt   = in_speed_pct;
          ms_nxt    = ms_wide[MW-1:0];
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        status_nxt = STATUS_OK;
        if (kind_r == KIND_TICK) begin
          ch_nxt    = 1'b0;
          state_nxt = ST_TICK;
        end else if (kind_r == KIND_BRAKE) begin
          active_nxt[ch_r] = 1'b0;
          fwd_nxt[ch_r]    = DUTY_MAX;
          rev_nxt[ch_r]    = DUTY_MAX;
          state_nxt        = ST_OUT;
        end else if (spd_r < SPEED_MIN || spd_r > SPEED_MAX) begin
          status_nxt = STATUS_RANGE;
          state_nxt  = ST_OUT;
        end else if (kind_r == KIND_SET || ms_r == '0) begin
          active_nxt[ch_r] = 1'b0;
          val_nxt          = spd_r;
          div_go           = 1'b1;
          div_op           = OP_DUTY;
          mul_a            = OW'(spd_abs);
          mul_b            = OW'(DUTY_MAX);
          div_den          = OW'(100);
        end else begin
          // Capture the ramp, then find the interval count.
          active_nxt[ch_r]  = 1'b0;
          start_nxt[ch_r]   = applied_r[ch_r];
          diff_nxt[ch_r]    = 9'(spd_r) - 9'(applied_r[ch_r]);
          total_nxt[ch_r]   = ms_r;
          idx_nxt[ch_r]     = NW'(1);
          elapsed_nxt[ch_r] = '0;
          div_go            = 1'b1;
          div_op            = OP_INTV;
          mul_a             = OW'(ms_r) + OW'(STEP_MS - 1);
          mul_b             = OW'(1);
          div_den           = OW'(STEP_MS);
        end
      end

      ST_TICK: begin
        if (active_r[ch_r]) begin
          if (elapsed_r[ch_r] < total_r[ch_r]) begin
            elapsed_nxt[ch_r] = elapsed_r[ch_r] + MW'(1);
          end
          div_go  = 1'b1;
          div_op  = OP_DUE;
          mul_a   = OW'(total_r[ch_r]);
          mul_b   = OW'(idx_r[ch_r]);
          div_den = OW'(intv_r[ch_r]);
        end else if (ch_r) begin
          state_nxt = ST_OUT;
        end else begin
          ch_nxt = 1'b1;
        end
      end

      ST_DIV: begin
        // One quotient bit per cycle.
        rem_nxt = fits ? trial[OW-1:0] : shifted[OW-1:0];
        q_nxt   = {q_r[PW-2:0], fits};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_POST;
        end
      end

      ST_POST: begin
        case (op_r)
          OP_INTV: begin
            intv_nxt[ch_r] = q_r[MW-1:0];
            div_go         = 1'b1;
            div_op         = OP_RVAL;
            mul_a          = OW'(diff_abs);
            mul_b          = OW'(idx_r[ch_r]);
            div_den        = OW'(q_r[MW-1:0]) + OW'(1);
          end
          OP_DUE: begin
            if (PW'(elapsed_r[ch_r]) >= q_r) begin
              idx_nxt[ch_r] = idx_r[ch_r] + NW'(1);
              div_go        = 1'b1;
              div_op        = OP_RVAL;
              mul_a         = OW'(diff_abs);
              mul_b         = OW'(idx_r[ch_r]) + OW'(1);
              div_den       = OW'(intv_r[ch_r]) + OW'(1);
            end else if (ch_r) begin
              state_nxt = ST_OUT;
            end else begin
              ch_nxt    = 1'b1;
              state_nxt = ST_TICK;
            end
          end
          OP_RVAL: begin
            // Truncation toward zero: divide the magnitude, then restore sign.
            val_nxt = rval_sum[7:0];
            div_go  = 1'b1;
            div_op  = OP_DUTY;
            mul_a   = OW'(rval_sum[7] ? 8'(-rval_sum[7:0]) : rval_sum[7:0]);
            mul_b   = OW'(DUTY_MAX);
            div_den = OW'(100);
          end
          default: begin
            fwd_nxt[ch_r]     = (val_r > 8'sd0) ? q_r[DUTY_BITS-1:0] : '0;
            rev_nxt[ch_r]     = (val_r < 8'sd0) ? q_r[DUTY_BITS-1:0] : '0;
            applied_nxt[ch_r] = val_r;
            if (kind_r == KIND_TICK) begin
              if (idx_r[ch_r] >= NW'(intv_r[ch_r]) + NW'(1)) begin
                active_nxt[ch_r] = 1'b0;
              end
              if (ch_r) begin
                state_nxt = ST_OUT;
              end else begin
                ch_nxt    = 1'b1;
                state_nxt = ST_TICK;
              end
            end else begin
              if (kind_r == KIND_RAMP && ms_r != '0) begin
                active_nxt[ch_r] = 1'b1;
              end
              state_nxt = ST_OUT;
            end
          end
        endcase
      end

      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Load the divider with a fresh registered product.
    if (div_go) begin
      q_nxt     = prod;
      rem_nxt   = '0;
      den_nxt   = div_den;
      cnt_nxt   = CW'(PW);
      op_nxt    = div_op;
      state_nxt = ST_DIV;
    end
  end

  // Control and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      status_r  <= STATUS_OK;
      applied_r <= '{default: '0};
      fwd_r     <= '{default: '0};
      rev_r     <= '{default: '0};
      active_r  <= '{default: 1'b0};
      start_r   <= '{default: '0};
      diff_r    <= '{default: '0};
      total_r   <= '{default: '0};
      intv_r    <= '{default: '0};
      idx_r     <= '{default: '0};
      elapsed_r <= '{default: '0};
    end else begin
      state_r   <= state_nxt;
      status_r  <= status_nxt;
      applied_r <= applied_nxt;
      fwd_r     <= fwd_nxt;
      rev_r     <= rev_nxt;
      active_r  <= active_nxt;
      start_r   <= start_nxt;
      diff_r    <= diff_nxt;
      total_r   <= total_nxt;
      intv_r    <= intv_nxt;
      idx_r     <= idx_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // Item and divider payload
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    kind_r <= kind_nxt;
    ch_r   <= ch_nxt;
    spd_r  <= spd_nxt;
    ms_r   <= ms_nxt;
    val_r  <= val_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule
`default_nettype wire
